// ===== design/prdf_pkg.sv =====
// Package for the periodic RDF histogram: constants, payload structs, command/status types.
// No dependencies.
`timescale 1ns / 1ps
package prdf_pkg;
  localparam int NUM_BINS = 4096;
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-1:0] REG_BOX_LENGTH = 4'h0;
  localparam logic [ADDR_W-1:0] REG_BIN_WIDTH  = 4'h4;
  localparam logic [ADDR_W-1:0] REG_BIN_LIMIT  = 4'h8;

  localparam logic [1:0] SPECIES_OXYGEN   = 2'd1;
  localparam logic [1:0] SPECIES_HYDROGEN = 2'd2;

  localparam logic REQ_ATOM = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic        frame_first;
    logic [1:0]  species;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] oxygen_count;
    logic [31:0] hydrogen_count;
    logic [31:0] frames_seen;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture item, compute offsets
    logic       img_start; // start image from counters
    logic [1:0] ix;
    logic [1:0] iy;
    logic [1:0] iz;
    logic       sq_start;  // take component magnitudes
    logic       sum_start; // square magnitudes; d2 sums them
    logic       sqrt_start;
    logic       div_start;
    logic       rd_issue;  // issue hist read
    logic       wr_commit; // write back
    logic       read_issue;
    logic       result_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic image_far;
  } sts_t;
endpackage

// ===== design/prdf_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module prdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/prdf_datapath.sv =====
// Datapath: origin, offsets, image squares, iterative sqrt and divide, histogram RAMs.
// Depends on prdf_pkg and prdf_ram.
`timescale 1ns / 1ps
module prdf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  prdf_pkg::cmd_t      cmd,
  output prdf_pkg::sts_t      sts,
  input  prdf_pkg::in_item_t  item,
  input  logic [30:0]         box_length,
  input  logic [15:0]         bin_width,
  input  logic [11:0]         bin_limit,
  input  logic                clr_we,
  input  logic [prdf_pkg::BIN_W-1:0] clr_addr,
  output prdf_pkg::out_item_t result
);
  import prdf_pkg::*;

  logic signed [33:0] dx, dy, dz;
  logic [1:0]  species;
  logic [11:0] read_bin;
  logic [31:0] frame_counter;
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic signed [34:0] cx, cy, cz;
  logic [27:0] mx, my, mz;
  logic [55:0] sx, sy, sz;
  logic [57:0] d2;
  logic [59:0] rem;
  logic [59:0] nval;
  logic [29:0] root;
  logic [4:0]  sq_cnt;
  logic        sq_busy;
  logic [29:0] dvd;
  logic [16:0] drem;
  logic [4:0]  dv_cnt;
  logic        dv_busy;
  logic [30:0] k;
  logic        k_ok;
  logic [BIN_W-1:0] bin_addr;
  logic        ox_we, hy_we;
  logic [31:0] ox_rd, hy_rd, cnt_rd, cnt_inc;
  logic [BIN_W-1:0] ram_addr;
  logic        read_valid;

  function automatic logic signed [34:0] img(input logic signed [33:0] d,
                                             input logic [1:0] s,
                                             input logic [30:0] a);
    logic signed [34:0] r;
    r = 35'(d);
    case (s)
      2'd0:    img = r - $signed({4'b0, a});
      2'd2:    img = r + $signed({4'b0, a});
      default: img = r;
    endcase
  endfunction

  function automatic logic near(input logic signed [34:0] c);
    near = (c > -$signed(35'h1000_0000)) && (c < $signed(35'h1000_0000));
  endfunction

  function automatic logic [27:0] mag(input logic signed [34:0] c);
    logic signed [34:0] a;
    a = c[34] ? -c : c;
    mag = a[27:0];
  endfunction

  // one remainder step of the square root
  logic [59:0] trial;
  logic [61:0] nshift;
  assign nshift = {rem, nval[59:58]};
  assign trial  = 60'({root, 2'b01});

  // one restoring divide step
  logic [17:0] dtrial;
  assign dtrial = {drem, dvd[29]} - {2'b0, bin_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      frame_counter <= '0;
      sq_busy <= 1'b0;
      dv_busy <= 1'b0;
    end else begin
      if (cmd.load) begin
        species  <= item.species;
        read_bin <= item.read_bin;
        if (item.frame_first && item.req_type == REQ_ATOM) begin
          origin_x <= item.pos_x;
          origin_y <= item.pos_y;
          origin_z <= item.pos_z;
          if (frame_counter != '1) begin
            frame_counter <= frame_counter + 32'd1;
          end
          dx <= '0;
          dy <= '0;
          dz <= '0;
        end else begin
          dx <= 34'(item.pos_x) - 34'(origin_x);
          dy <= 34'(item.pos_y) - 34'(origin_y);
          dz <= 34'(item.pos_z) - 34'(origin_z);
        end
      end
      if (cmd.img_start) begin
        cx <= img(dx, cmd.ix, box_length);
        cy <= img(dy, cmd.iy, box_length);
        cz <= img(dz, cmd.iz, box_length);
      end
      if (cmd.sq_start) begin
        mx <= mag(cx);
        my <= mag(cy);
        mz <= mag(cz);
      end
      if (cmd.sum_start) begin
        sx <= mx * mx;
        sy <= my * my;
        sz <= mz * mz;
      end
      if (cmd.sqrt_start) begin
        nval <= {d2, 2'b00};
        rem <= '0;
        root <= '0;
        sq_cnt <= '0;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (62'(trial) <= nshift) begin
          rem  <= 60'(nshift - 62'(trial));
          root <= {root[28:0], 1'b1};
        end else begin
          rem  <= nshift[59:0];
          root <= {root[28:0], 1'b0};
        end
        nval <= {nval[57:0], 2'b00};
        sq_cnt <= sq_cnt + 5'd1;
        if (sq_cnt == 5'd29) begin
          sq_busy <= 1'b0;
        end
      end
      if (cmd.div_start) begin
        dvd <= root;
        drem <= '0;
        dv_cnt <= '0;
        dv_busy <= 1'b1;
      end else if (dv_busy) begin
        if (!dtrial[17]) begin
          drem <= dtrial[16:0];
          dvd  <= {dvd[28:0], 1'b1};
        end else begin
          drem <= {drem[15:0], dvd[29]};
          dvd  <= {dvd[28:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 5'd1;
        if (dv_cnt == 5'd29) begin
          dv_busy <= 1'b0;
        end
      end
      if (cmd.rd_issue) begin
        k_ok <= (bin_width != '0) && (k <= 31'(bin_limit)) && (k < 31'(NUM_BINS));
        bin_addr <= k[BIN_W-1:0];
      end
      if (cmd.result_load) begin
        result.oxygen_count   <= read_valid ? ox_rd : '0;
        result.hydrogen_count <= read_valid ? hy_rd : '0;
        result.frames_seen    <= frame_counter;
      end
    end
  end

  assign d2 = 58'(sx) + 58'(sy) + 58'(sz);
  assign k  = 31'((32'(dvd) + 32'd1) >> 1);
  assign read_valid = 32'(read_bin) < 32'(NUM_BINS);

  assign sts.sqrt_done = sq_busy && sq_cnt == 5'd29;
  assign sts.div_done  = dv_busy && dv_cnt == 5'd29;
  assign sts.image_far = !(near(cx) && near(cy) && near(cz));

  assign cnt_rd  = (species == SPECIES_OXYGEN) ? ox_rd : hy_rd;
  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 32'd1;
  assign ox_we = clr_we || (cmd.wr_commit && k_ok && species == SPECIES_OXYGEN);
  assign hy_we = clr_we || (cmd.wr_commit && k_ok && species == SPECIES_HYDROGEN);

  always_comb begin
    if (clr_we) begin
      ram_addr = clr_addr;
    end else if (cmd.read_issue) begin
      ram_addr = read_bin[BIN_W-1:0];
    end else begin
      ram_addr = bin_addr;
    end
  end

  prdf_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_ox (
    .clk(clk), .we(ox_we), .addr(ram_addr),
    .wdata(clr_we ? 32'd0 : cnt_inc), .rdata(ox_rd)
  );
  prdf_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_hy (
    .clk(clk), .we(hy_we), .addr(ram_addr),
    .wdata(clr_we ? 32'd0 : cnt_inc), .rdata(hy_rd)
  );
endmodule

// ===== design/prdf_ctrl.sv =====
// Controller: clearing pass, image loop, histogram update and read item sequencing.
// Depends on prdf_pkg.
`timescale 1ns / 1ps
module prdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [1:0]          in_species,
  output logic                out_valid,
  input  logic                out_stall,
  output prdf_pkg::cmd_t      cmd,
  input  prdf_pkg::sts_t      sts,
  output logic                clr_we,
  output logic [prdf_pkg::BIN_W-1:0] clr_addr
);
  import prdf_pkg::*;

  typedef enum logic [3:0] {
    CLEAR, IDLE, IMG, SQ, SUM, SQRT, DIV, RD, RDW, WR, NEXT, RREAD, RWAIT, RLOAD
  } state_t;

  state_t state;
  logic [1:0] ix, iy, iz;
  logic       accept;
  // sqrt and div start pulses are registered outputs
  logic sqrt_go, div_go;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != IDLE) || out_valid;
  assign clr_we   = (state == CLEAR);

  always_comb begin
    cmd = '0;
    cmd.ix = ix;
    cmd.iy = iy;
    cmd.iz = iz;
    cmd.load = accept;
    cmd.img_start = (state == IMG);
    cmd.sq_start = (state == SQ);
    cmd.sum_start = (state == SUM);
    cmd.sqrt_start = sqrt_go;
    cmd.div_start = div_go;
    cmd.rd_issue = (state == RD);
    cmd.wr_commit = (state == WR);
    cmd.read_issue = (state == RREAD) || (state == RWAIT);
    cmd.result_load = (state == RLOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      ix <= '0;
      iy <= '0;
      iz <= '0;
      sqrt_go <= 1'b0;
      div_go <= 1'b0;
    end else begin
      sqrt_go <= 1'b0;
      div_go <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BIN_W'(NUM_BINS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            ix <= '0;
            iy <= '0;
            iz <= '0;
            if (in_req_type == REQ_READ) begin
              state <= RREAD;
            end else if (in_species inside {SPECIES_OXYGEN, SPECIES_HYDROGEN}) begin
              state <= IMG;
            end
          end
        end
        IMG: state <= SQ;
        SQ: begin
          if (sts.image_far) begin
            state <= NEXT;
          end else begin
            state <= SUM;
          end
        end
        SUM: begin
          sqrt_go <= 1'b1;
          state <= SQRT;
        end
        SQRT: begin
          if (sts.sqrt_done) begin
            div_go <= 1'b1;
            state <= DIV;
          end
        end
        DIV: begin
          if (sts.div_done) begin
            state <= RD;
          end
        end
        RD: state <= RDW;
        RDW: state <= WR;
        WR: state <= NEXT;
        NEXT: begin
          if (iz != 2'd2) begin
            iz <= iz + 2'd1;
            state <= IMG;
          end else if (iy != 2'd2) begin
            iz <= '0;
            iy <= iy + 2'd1;
            state <= IMG;
          end else if (ix != 2'd2) begin
            iz <= '0;
            iy <= '0;
            ix <= ix + 2'd1;
            state <= IMG;
          end else begin
            state <= IDLE;
          end
        end
        RREAD: state <= RWAIT;
        RWAIT: state <= RLOAD;
        RLOAD: begin
          out_valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== design/periodic_rdf_histogram.sv =====
// Periodic RDF histogram: top level with APB registers, controller and datapath.
// An oxygen or hydrogen atom runs 27 images (sqrt and divide are one bit a cycle, 30 steps
// each); a far image skips sqrt, divide and update; input stalls until the last image is done.
// A read item passes RREAD, RWAIT and RLOAD before out_valid rises; one item in flight at a time.
// After reset a clearing pass over all 4096 bins zeroes both histograms; no item is taken then.
`timescale 1ns / 1ps
module periodic_rdf_histogram (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prdf_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prdf_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [prdf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import prdf_pkg::*;

  logic [30:0] box_length;
  logic [15:0] bin_width;
  logic [11:0] bin_limit;
  cmd_t cmd;
  sts_t sts;
  logic clr_we;
  logic [BIN_W-1:0] clr_addr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= 31'd655360;
      bin_width  <= 16'd328;
      bin_limit  <= 12'd4095;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_BOX_LENGTH: box_length <= pwdata[30:0];
        REG_BIN_WIDTH:  bin_width  <= pwdata[15:0];
        REG_BIN_LIMIT:  bin_limit  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_BOX_LENGTH: prdata = {1'b0, box_length};
      REG_BIN_WIDTH:  prdata = {16'b0, bin_width};
      REG_BIN_LIMIT:  prdata = {20'b0, bin_limit};
      default:        prdata = '0;
    endcase
  end

  prdf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_item.req_type), .in_species(in_item.species),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts), .clr_we(clr_we), .clr_addr(clr_addr)
  );

  prdf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .item(in_item),
    .box_length(box_length), .bin_width(bin_width), .bin_limit(bin_limit),
    .clr_we(clr_we), .clr_addr(clr_addr), .result(out_item)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_sqrt_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> $past(sts.sqrt_done))
    else $error("divide started before root done");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_issue, cmd.wr_commit, cmd.read_issue, cmd.result_load}))
    else $error("conflicting RAM commands");
endmodule

// ===== verif/periodic_rdf_histogram_test.sv =====
// Self-checking testbench for periodic_rdf_histogram: atom and read items against an
// in-bench histogram predictor, APB register phases, random idling on both channels.
// Depends on prdf_pkg and the periodic_rdf_histogram RTL only.
`timescale 1ns / 1ps
module periodic_rdf_histogram_test;
  import prdf_pkg::*;

  localparam int WATCH_LIMIT = 40000;
  localparam int SETTLE = 2500;
  localparam longint FAR = longint'(1) << 28;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  periodic_rdf_histogram dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [30:0] box_len;
  logic [15:0] bin_w;
  logic [11:0] bin_lim;
  logic signed [31:0] org_x, org_y, org_z;
  logic [31:0] oxy_hist [NUM_BINS];
  logic [31:0] hyd_hist [NUM_BINS];
  logic [31:0] frame_cnt;
  out_item_t pending_reads [$];

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int atoms_sent = 0;
  int reads_sent = 0;
  int reads_checked = 0;
  int idle_cycles = 0;
  row_t rows [$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_sq(longint c);
    longint unsigned m;
    m = (c < 0) ? longint'(-c) : longint'(c);
    return m * m;
  endfunction

  task automatic bin_image(bit oxy, longint cx, longint cy, longint cz);
    longint unsigned q, k;
    if (bin_w == 0) return;
    if (cx <= -FAR || cx >= FAR || cy <= -FAR || cy >= FAR || cz <= -FAR || cz >= FAR)
      return;
    q = int_sqrt((mag_sq(cx) + mag_sq(cy) + mag_sq(cz)) << 2) / bin_w;
    k = (q + 1) >> 1;
    if (k > bin_lim || k >= NUM_BINS) return;
    if (oxy) begin
      if (oxy_hist[k] != '1) oxy_hist[k]++;
    end else begin
      if (hyd_hist[k] != '1) hyd_hist[k]++;
    end
  endtask

  task automatic predict_item(in_item_t it, bit typed, out_item_t want);
    out_item_t r;
    longint dx, dy, dz, a;
    if (it.req_type == REQ_READ) begin
      r.oxygen_count = oxy_hist[it.read_bin];
      r.hydrogen_count = hyd_hist[it.read_bin];
      r.frames_seen = frame_cnt;
      pending_reads.push_back(typed ? want : r);
      reads_sent++;
      return;
    end
    atoms_sent++;
    if (it.frame_first) begin
      org_x = it.pos_x;
      org_y = it.pos_y;
      org_z = it.pos_z;
      if (frame_cnt != '1) frame_cnt++;
    end
    if (it.species != SPECIES_OXYGEN && it.species != SPECIES_HYDROGEN) return;
    dx = longint'(it.pos_x) - longint'(org_x);
    dy = longint'(it.pos_y) - longint'(org_y);
    dz = longint'(it.pos_z) - longint'(org_z);
    a = longint'({1'b0, box_len});
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        for (int l = -1; l <= 1; l++)
          bin_image(it.species == SPECIES_OXYGEN, dx + i * a, dy + j * a, dz + l * a);
  endtask

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("mismatch at %0t: result item with none expected", $realtime);
        errors++;
      end else begin
        out_item_t w;
        w = pending_reads.pop_front();
        reads_checked++;
        if (out_item.oxygen_count !== w.oxygen_count)
          note_mismatch("oxygen_count", out_item.oxygen_count, w.oxygen_count);
        if (out_item.hydrogen_count !== w.hydrogen_count)
          note_mismatch("hydrogen_count", out_item.hydrogen_count, w.hydrogen_count);
        if (out_item.frames_seen !== w.frames_seen)
          note_mismatch("frames_seen", out_item.frames_seen, w.frames_seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCH_LIMIT);
      $display("periodic_rdf_histogram regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_item(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it, typed, want);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr)
      REG_BOX_LENGTH: box_len = data[30:0];
      REG_BIN_WIDTH:  bin_w = data[15:0];
      REG_BIN_LIMIT:  bin_lim = data[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t mk_item(logic rq, logic ff, logic [1:0] sp,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [11:0] rb);
    in_item_t it;
    it.req_type = rq;
    it.frame_first = ff;
    it.species = sp;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.read_bin = rb;
    return it;
  endfunction

  function automatic logic [31:0] near_coord(logic [31:0] base, int spread);
    if ($urandom_range(99) < 12) return $urandom;
    return base + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int spread, r;
    spread = int'(bin_w) * 2048;
    if (spread < 256) spread = 256;
    if (spread > (1 << 26)) spread = 1 << 26;
    it = '0;
    it.frame_first = 1'($urandom_range(1));
    it.species = 2'($urandom_range(3));
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.read_bin = ($urandom_range(1)) ? 12'($urandom_range(NUM_BINS - 1)) :
                  12'($urandom_range(64));
    if ($urandom_range(99) < 40) begin
      it.req_type = REQ_READ;
    end else begin
      it.req_type = REQ_ATOM;
      it.frame_first = ($urandom_range(9) == 0);
      r = $urandom_range(99);
      it.species = (r < 35) ? SPECIES_OXYGEN : (r < 70) ? SPECIES_HYDROGEN :
                   (r < 90) ? 2'd0 : 2'd3;
      it.pos_x = near_coord(org_x, spread);
      it.pos_y = near_coord(org_y, spread);
      it.pos_z = near_coord(org_z, spread);
    end
    return it;
  endfunction

  task automatic add_row(in_item_t it, bit typed, logic [31:0] o, logic [31:0] h,
                         logic [31:0] f);
    row_t rw;
    rw.item = it;
    rw.typed = typed;
    rw.want = '{oxygen_count: o, hydrogen_count: h, frames_seen: f};
    rows.push_back(rw);
  endtask

  task automatic random_phase(int n, bit hold_off);
    for (int i = 0; i < n; i++) begin
      if (hold_off && i == n / 2) begin
        in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
      end
      put_item(random_item(), 1'b0, '0);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    box_len = 31'd655360;
    bin_w = 16'd328;
    bin_lim = 12'd4095;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    frame_cnt = '0;
    foreach (oxy_hist[i]) begin
      oxy_hist[i] = '0;
      hyd_hist[i] = '0;
    end

    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd0), 1, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'hFFF), 1, 0, 0, 0);
    add_row(mk_item(REQ_READ, 1, 3, '1, '1, '1, 12'd5), 1, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 1, 0, 32'h10000, 32'hFFFE0000, 32'h30000, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd0), 1, 0, 0, 1);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_OXYGEN, 32'h10000, 32'hFFFE0000, 32'h30000, 0),
            0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_HYDROGEN, 32'h7FFFFFFF, 32'h80000000, 0, 0),
            0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 1, 2'd3, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_OXYGEN, 32'd328, 32'd164, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 1, SPECIES_HYDROGEN, 32'h80000000, 32'h80000000,
                    32'h80000000, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_OXYGEN, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_HYDROGEN, 32'h80000148, 32'h80000000,
                    32'h80000000, 0), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd0), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd1), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd1), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'd2000), 0, 0, 0, 0);
    add_row(mk_item(REQ_ATOM, 0, SPECIES_OXYGEN, 32'h5555AAAA, 32'hAAAA5555, 32'h0F0F0F0F,
                    12'hAAA), 0, 0, 0, 0);
    add_row(mk_item(REQ_READ, 0, 0, 0, 0, 0, 12'h555), 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle = 22;
    recv_idle = 63;
    foreach (rows[i]) put_item(rows[i].item, rows[i].typed, rows[i].want);
    random_phase(135, 1'b0);
    drain();

    // extremes: zero box, finest bins, only bin zero counted; upper bits dropped
    reg_write(REG_BOX_LENGTH, 32'h80000000);
    reg_write(REG_BIN_WIDTH, 32'hFFFF0001);
    reg_write(REG_BIN_LIMIT, 32'hFFFFF000);
    send_idle = 63;
    recv_idle = 22;
    random_phase(135, 1'b0);
    drain();

    reg_write(REG_BOX_LENGTH, 32'hFFFFFFFF);
    reg_write(REG_BIN_WIDTH, 32'h0000FFFF);
    reg_write(REG_BIN_LIMIT, 32'h00000FFF);
    reg_write(4'hC, 32'hDEADBEEF);
    send_idle = 0;
    recv_idle = 0;
    random_phase(135, 1'b1);
    drain();

    reg_write(REG_BOX_LENGTH, $urandom_range(4000000, 100000));
    reg_write(REG_BIN_WIDTH, $urandom_range(3000, 200));
    reg_write(REG_BIN_LIMIT, $urandom_range(4095, 100));
    random_phase(135, 1'b0);
    drain();

    // zero bin width: nothing may be counted
    reg_write(REG_BIN_WIDTH, 32'h00010000);
    random_phase(30, 1'b0);
    drain();

    $display("covered %0d atom items and %0d read items over five register settings",
             atoms_sent, reads_sent);
    $display("%0d read results checked, %0d mismatches", reads_checked, errors);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("periodic_rdf_histogram regression: pass");
    end else begin
      $display("periodic_rdf_histogram regression: fail");
    end
    $finish;
  end
endmodule
